FILE: sv/escp_pkg.sv
// Shared types, widths, codes and helpers of the encoder scan position controller.
package escp_pkg;

  localparam int CHANNELS_DEF = 2;

  localparam int ANGLE_W  = 18;
  localparam int TURN_W   = 22;
  localparam int POS_W    = 40;
  localparam int ERR_W    = POS_W + 1;
  localparam int TENTHS_W = 12;
  localparam int PWM_W    = 16;
  localparam int GAIN_W   = 24;
  localparam int MAG_W    = 17;
  localparam int GAIN_FRAC = 16;
  localparam int TPROD_W  = 30;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [ANGLE_W-1:0] HALF_REV  = 18'd131072;
  localparam logic [MAG_W-1:0]   ERR_CLAMP = 17'd65536;
  localparam logic [PWM_W-1:0]   PWM_MAX   = 16'hFFFF;
  localparam logic [TPROD_W-1:0] TENTHS_PER_REV = 30'd3600;

  localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
  localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0]  POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0]  POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};

  localparam logic [ANGLE_W-1:0] DEADBAND_RST = 18'd256;
  localparam logic [ANGLE_W-1:0] HALF_RST     = 18'd65536;
  localparam logic [GAIN_W-1:0]  GAIN_RST     = 24'd65536;
  localparam logic [PWM_W-1:0]   FLOOR_RST    = 16'd0;
  localparam logic [PWM_W-1:0]   CEILING_RST  = 16'd999;

  typedef enum logic [1:0] {
    DRIVE_STOP = 2'd0,
    DRIVE_FWD  = 2'd1,
    DRIVE_REV  = 2'd2
  } drive_t;

  typedef enum logic {
    ACT_HOME = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    REG_DEADBAND = 3'd0,
    REG_HALF     = 3'd1,
    REG_GAIN     = 3'd2,
    REG_FLOOR    = 3'd3,
    REG_CEILING  = 3'd4
  } reg_idx_t;

  function automatic logic signed [POS_W-1:0] sat40(input logic signed [ERR_W-1:0] v);
    if (v[ERR_W-1] != v[ERR_W-2]) begin
      return v[ERR_W-1] ? POS_MIN : POS_MAX;
    end
    return v[POS_W-1:0];
  endfunction

endpackage

FILE: sv/escp_if.sv
// Sample and result channel interfaces of the encoder scan position controller.
interface escp_in_if;
  import escp_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic               channel;
  logic [ANGLE_W-1:0] raw_angle;

  modport source (output valid, output action, output channel, output raw_angle, input ready);
  modport sink   (input valid, input action, input channel, input raw_angle, output ready);
endinterface

interface escp_out_if;
  import escp_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       out_channel;
  logic signed [POS_W-1:0]    position;
  logic signed [TENTHS_W-1:0] angle_tenths;
  logic [1:0]                 drive;
  logic [PWM_W-1:0]           drive_pwm;
  logic                       heading_up;

  modport source (output valid, output out_channel, output position, output angle_tenths,
                  output drive, output drive_pwm, output heading_up, input ready);
  modport sink   (input valid, input out_channel, input position, input angle_tenths,
                  input drive, input drive_pwm, input heading_up, output ready);
endinterface

FILE: sv/encoder_scan_position_controller.sv
// Top level: multi-turn encoder unwrap, home capture and proportional scan control.
//
// sample channel: one 18-bit absolute angle per transfer, with channel and action
// (home capture or control tick). result channel: one result per sample, in order.
// APB port: deadband, scan half-width, gain, PWM floor and ceiling at 4*index;
// pready is tied high, reads return the register value. Write only while idle.
//
// Pipeline: input register, unwrap/state stage, multiply stage into the result
// register. One sample per cycle is sustained while the receiver does not stall,
// including back-to-back samples on the same channel, since the per-channel
// state update closes in the single state stage.
// The gain and tenths-of-degree multiplies sit in the last stage.
//
// Reset clears all per-channel state (turns, home, target, direction, priming)
// and loads the register defaults. When the receiver stalls, the result register
// holds; the stages behind it keep filling, and sample.ready drops only once all
// three stages hold a transfer.
module encoder_scan_position_controller #(
  parameter int CHANNELS = escp_pkg::CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [escp_pkg::ADDR_W-1:0] paddr,
  input  logic [escp_pkg::DATA_W-1:0] pwdata,
  output logic [escp_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  escp_in_if.sink                     sample,
  escp_out_if.source                  result
);
  import escp_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [ANGLE_W:0] D_POS = $signed({1'b0, HALF_REV});
  localparam logic signed [ANGLE_W:0] D_NEG = -D_POS;

  // configuration
  logic [ANGLE_W-1:0] deadband;
  logic [ANGLE_W-1:0] half_width;
  logic [GAIN_W-1:0]  gain;
  logic [PWM_W-1:0]   pwm_floor;
  logic [PWM_W-1:0]   pwm_ceiling;
  logic               cfg_wr;
  logic [2:0]         reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_sel = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband    <= DEADBAND_RST;
      half_width  <= HALF_RST;
      gain        <= GAIN_RST;
      pwm_floor   <= FLOOR_RST;
      pwm_ceiling <= CEILING_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_DEADBAND: deadband    <= pwdata[ANGLE_W-1:0];
        REG_HALF:     half_width  <= pwdata[ANGLE_W-1:0];
        REG_GAIN:     gain        <= pwdata[GAIN_W-1:0];
        REG_FLOOR:    pwm_floor   <= pwdata[PWM_W-1:0];
        REG_CEILING:  pwm_ceiling <= pwdata[PWM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DEADBAND: prdata = DATA_W'(deadband);
      REG_HALF:     prdata = DATA_W'(half_width);
      REG_GAIN:     prdata = DATA_W'(gain);
      REG_FLOOR:    prdata = DATA_W'(pwm_floor);
      REG_CEILING:  prdata = DATA_W'(pwm_ceiling);
      default:      prdata = '0;
    endcase
  end

  // pipeline flow control
  logic s0_valid, s1_valid, out_valid;
  logic s0_en, s1_en, out_en;

  assign out_en       = !out_valid || result.ready;
  assign s1_en        = !s1_valid || out_en;
  assign s0_en        = !s0_valid || s1_en;
  assign sample.ready = s0_en;

  // input register
  logic               s0_action;
  logic               s0_channel;
  logic [ANGLE_W-1:0] s0_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_en) begin
      s0_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_en && sample.valid) begin
      s0_action  <= sample.action;
      s0_channel <= sample.channel;
      s0_raw     <= sample.raw_angle;
    end
  end

  // per-channel state
  logic [ANGLE_W-1:0]       last_raw   [CHANNELS];
  logic                     primed     [CHANNELS];
  logic signed [TURN_W-1:0] turn_count [CHANNELS];
  logic signed [POS_W-1:0]  home_pos   [CHANNELS];
  logic signed [POS_W-1:0]  target_pos [CHANNELS];
  logic                     going_up   [CHANNELS];

  logic [CH_W-1:0]          idx;
  logic signed [ANGLE_W:0]  d;
  logic signed [TURN_W-1:0] turn_next;
  logic signed [POS_W-1:0]  pos;
  logic signed [ERR_W-1:0]  pos_x, home_x, target_x, half_x, db_x;
  logic signed [ERR_W-1:0]  err, nerr, rel, abs_err;
  logic                     err_gt, err_lt;
  logic [ANGLE_W-1:0]       m;
  logic                     tneg;
  logic [ANGLE_W-1:0]       tmag;
  logic [MAG_W-1:0]         mag;
  logic signed [POS_W-1:0]  home_next, target_next;
  logic                     up_next;
  drive_t                   drive_next;
  logic                     state_wr;

  assign idx      = (CHANNELS > 1) ? CH_W'(s0_channel) : '0;
  assign state_wr = s1_en && s0_valid;

  always_comb begin
    d = $signed({1'b0, s0_raw}) - $signed({1'b0, last_raw[idx]});
    turn_next = turn_count[idx];
    if (primed[idx]) begin
      if (d < D_NEG && turn_count[idx] != TURN_MAX) begin
        turn_next = turn_count[idx] + TURN_W'(1);
      end else if (d > D_POS && turn_count[idx] != TURN_MIN) begin
        turn_next = turn_count[idx] - TURN_W'(1);
      end
    end
    pos      = $signed({turn_next, s0_raw});
    pos_x    = ERR_W'(pos);
    home_x   = ERR_W'(home_pos[idx]);
    target_x = ERR_W'(target_pos[idx]);
    half_x   = $signed({{(ERR_W-ANGLE_W){1'b0}}, half_width});
    db_x     = $signed({{(ERR_W-ANGLE_W){1'b0}}, deadband});

    err    = target_x - pos_x;
    nerr   = pos_x - target_x;
    err_gt = err > db_x;
    err_lt = nerr > db_x;
    abs_err = err_gt ? err : nerr;
    mag = (abs_err > $signed(ERR_W'(ERR_CLAMP))) ? ERR_CLAMP : abs_err[MAG_W-1:0];

    rel = pos_x - home_x;
    m   = rel[ANGLE_W-1:0];
    if (m > HALF_REV) begin
      tneg = 1'b1;
      tmag = ANGLE_W'(0) - m;
    end else if (m == HALF_REV && rel[ERR_W-1]) begin
      tneg = 1'b1;
      tmag = HALF_REV;
    end else begin
      tneg = 1'b0;
      tmag = m;
    end

    home_next   = home_pos[idx];
    target_next = target_pos[idx];
    up_next     = going_up[idx];
    drive_next  = DRIVE_STOP;
    if (s0_action == ACT_HOME) begin
      home_next   = pos;
      target_next = sat40(pos_x - half_x);
      up_next     = 1'b0;
      tneg        = 1'b0;
      tmag        = '0;
    end else begin
      if (err_gt) begin
        drive_next = DRIVE_FWD;
      end else if (err_lt) begin
        drive_next = DRIVE_REV;
      end
      if (going_up[idx] && err < db_x) begin
        up_next     = 1'b0;
        target_next = sat40(home_x - half_x);
      end else if (!going_up[idx] && nerr < db_x) begin
        up_next     = 1'b1;
        target_next = sat40(home_x + half_x);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_raw[i]   <= '0;
        primed[i]     <= 1'b0;
        turn_count[i] <= '0;
        home_pos[i]   <= '0;
        target_pos[i] <= '0;
        going_up[i]   <= 1'b0;
      end
    end else if (state_wr) begin
      last_raw[idx]   <= s0_raw;
      primed[idx]     <= 1'b1;
      turn_count[idx] <= turn_next;
      home_pos[idx]   <= home_next;
      target_pos[idx] <= target_next;
      going_up[idx]   <= up_next;
    end
  end

  // state stage register
  logic                    s1_channel;
  logic signed [POS_W-1:0] s1_pos;
  drive_t                  s1_drive;
  logic [MAG_W-1:0]        s1_mag;
  logic                    s1_tneg;
  logic [ANGLE_W-1:0]      s1_tmag;
  logic                    s1_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (state_wr) begin
      s1_channel <= s0_channel;
      s1_pos     <= pos;
      s1_drive   <= drive_next;
      s1_mag     <= mag;
      s1_tneg    <= tneg;
      s1_tmag    <= tmag;
      s1_up      <= up_next;
    end
  end

  // multiply stage
  logic [MAG_W+GAIN_W-1:0]           prod;
  logic [MAG_W+GAIN_W-GAIN_FRAC-1:0] p_shift;
  logic [PWM_W-1:0]                  p_sat, p_ceil, pwm_next;
  logic [TPROD_W-1:0]                tprod;
  logic [TENTHS_W-1:0]               tval;
  logic signed [TENTHS_W-1:0]        tenths_next;

  always_comb begin
    prod    = (MAG_W+GAIN_W)'(s1_mag) * (MAG_W+GAIN_W)'(gain);
    p_shift = prod[MAG_W+GAIN_W-1:GAIN_FRAC];
    p_sat   = (|p_shift[MAG_W+GAIN_W-GAIN_FRAC-1:PWM_W]) ? PWM_MAX : p_shift[PWM_W-1:0];
    p_ceil  = (p_sat > pwm_ceiling) ? pwm_ceiling : p_sat;
    pwm_next = (p_ceil < pwm_floor) ? pwm_floor : p_ceil;
    if (s1_drive == DRIVE_STOP) begin
      pwm_next = '0;
    end

    tprod = TPROD_W'(s1_tmag) * TENTHS_PER_REV;
    tval  = tprod[TPROD_W-1:ANGLE_W];
    tenths_next = s1_tneg ? -$signed(tval) : $signed(tval);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid) begin
      result.out_channel  <= s1_channel;
      result.position     <= s1_pos;
      result.angle_tenths <= tenths_next;
      result.drive        <= s1_drive;
      result.drive_pwm    <= pwm_next;
      result.heading_up   <= s1_up;
    end
  end

  assign result.valid = out_valid;

endmodule

FILE: sv/escp_checker.sv
// Port-level checks of the encoder scan position controller, bound to the top level.
module escp_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 res_valid,
  input logic                                 res_ready,
  input logic signed [escp_pkg::POS_W-1:0]    res_position,
  input logic signed [escp_pkg::TENTHS_W-1:0] res_tenths,
  input logic [1:0]                           res_drive,
  input logic [escp_pkg::PWM_W-1:0]           res_pwm
);
  import escp_pkg::*;

  localparam logic signed [TENTHS_W-1:0] TENTHS_LIM = 12'sd1800;

  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_position) && $stable(res_pwm))
    else $error("stalled result changed");

  a_stop_pwm: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_drive == DRIVE_STOP |-> res_pwm == '0)
    else $error("pwm nonzero while stopped");

  a_tenths_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_tenths <= TENTHS_LIM && res_tenths >= -TENTHS_LIM)
    else $error("angle tenths out of range");

endmodule

bind encoder_scan_position_controller escp_checker u_escp_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .res_position (result.position),
  .res_tenths   (result.angle_tenths),
  .res_drive    (result.drive),
  .res_pwm      (result.drive_pwm)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the encoder scan position controller: unwrap, home, drive, scan.
module tb;
  import escp_pkg::*;

  localparam longint REV            = 262144;
  localparam int     HOLD_CYCLES    = 200;
  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     SETTLE_CYCLES  = 6;
  localparam int     SPARE_REG      = 7;

  typedef struct {
    logic [ANGLE_W-1:0] last_raw;
    bit                 primed;
    int                 turns;
    longint             home;
    longint             target;
    bit                 up;
  } scanner_t;

  typedef struct {
    bit                         channel;
    logic signed [POS_W-1:0]    position;
    logic signed [TENTHS_W-1:0] tenths;
    drive_t                     drive;
    logic [PWM_W-1:0]           pwm;
    bit                         up;
  } move_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  escp_in_if  sample_if();
  escp_out_if result_if();

  encoder_scan_position_controller dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sample  (sample_if),
    .result  (result_if)
  );

  scanner_t           scanners[CHANNELS_DEF];
  logic [ANGLE_W-1:0] walk_angle[CHANNELS_DEF];
  move_t              pending_moves[$];
  move_t              head_move;
  logic [ANGLE_W-1:0] deadband;
  logic [ANGLE_W-1:0] half_width;
  logic [GAIN_W-1:0]  gain;
  logic [PWM_W-1:0]   pwm_floor;
  logic [PWM_W-1:0]   pwm_ceiling;
  int                 gap_pct;
  int                 stall_pct;
  int                 mismatches = 0;
  logic               holding;
  event               start_hold;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint clamp_pos(longint v);
    if (v > longint'(POS_MAX)) return longint'(POS_MAX);
    if (v < longint'(POS_MIN)) return longint'(POS_MIN);
    return v;
  endfunction

  function automatic logic signed [TENTHS_W-1:0] tenths_from_home(longint rel);
    longint m;
    longint mag;
    m = rel & (REV - 1);
    if (m > REV / 2) m = m - REV;
    else if (m == REV / 2 && rel < 0) m = -m;
    mag = (m < 0 ? -m : m) * 3600 / REV;
    return TENTHS_W'(m < 0 ? -mag : mag);
  endfunction

  function automatic logic [PWM_W-1:0] pwm_for(longint mag);
    longint p;
    if (mag > longint'(ERR_CLAMP)) mag = longint'(ERR_CLAMP);
    p = (mag * longint'(gain)) >>> GAIN_FRAC;
    if (p > longint'(PWM_MAX)) p = longint'(PWM_MAX);
    if (p > longint'(pwm_ceiling)) p = longint'(pwm_ceiling);
    if (p < longint'(pwm_floor)) p = longint'(pwm_floor);
    return PWM_W'(p);
  endfunction

  function automatic move_t advance_scanner(action_t act, bit ch, logic [ANGLE_W-1:0] raw);
    scanner_t s;
    move_t    m;
    int       jump;
    longint   pos;
    longint   err;
    longint   db;
    s = scanners[ch];
    if (!s.primed) begin
      s.primed = 1'b1;
    end else begin
      jump = int'(raw) - int'(s.last_raw);
      if (jump < -int'(HALF_REV) && s.turns < int'(TURN_MAX)) s.turns++;
      else if (jump > int'(HALF_REV) && s.turns > int'(TURN_MIN)) s.turns--;
    end
    s.last_raw = raw;
    pos = longint'(s.turns) * REV + longint'(raw);
    db = longint'(deadband);
    m.channel = ch;
    m.position = POS_W'(pos);
    m.tenths = '0;
    m.drive = DRIVE_STOP;
    m.pwm = '0;
    if (act == ACT_HOME) begin
      s.home = pos;
      s.target = clamp_pos(pos - longint'(half_width));
      s.up = 1'b0;
    end else begin
      m.tenths = tenths_from_home(pos - s.home);
      err = s.target - pos;
      if (err > db) begin
        m.drive = DRIVE_FWD;
        m.pwm = pwm_for(err);
      end else if (err < -db) begin
        m.drive = DRIVE_REV;
        m.pwm = pwm_for(-err);
      end
      if (s.up && err < db) begin
        s.up = 1'b0;
        s.target = clamp_pos(s.home - longint'(half_width));
      end else if (!s.up && err > -db) begin
        s.up = 1'b1;
        s.target = clamp_pos(s.home + longint'(half_width));
      end
    end
    m.up = s.up;
    scanners[ch] = s;
    return m;
  endfunction

  task automatic check_field(string what, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // result side: compare each transfer, then pick ready for the next edge
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_moves.size() == 0) begin
        $display("%0t ns: result transfer with nothing outstanding", $time);
        mismatches++;
      end else begin
        head_move = pending_moves.pop_front();
        check_field("out_channel", head_move.channel, result_if.out_channel);
        check_field("position", head_move.position, result_if.position);
        check_field("angle_tenths", head_move.tenths, result_if.angle_tenths);
        check_field("drive", head_move.drive, result_if.drive);
        check_field("drive_pwm", head_move.pwm, result_if.drive_pwm);
        check_field("heading_up", head_move.up, result_if.heading_up);
      end
    end
    result_if.ready <= !holding && ($urandom_range(99) >= stall_pct);
  end

  initial begin
    holding = 1'b0;
    forever begin
      @(start_hold);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      holding <= 1'b0;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic reset_model();
    deadband = DEADBAND_RST;
    half_width = HALF_RST;
    gain = GAIN_RST;
    pwm_floor = FLOOR_RST;
    pwm_ceiling = CEILING_RST;
    foreach (scanners[i]) begin
      scanners[i] = '{default: 0};
      walk_angle[i] = '0;
    end
  endtask

  task automatic send_sample(action_t act, bit ch, logic [ANGLE_W-1:0] raw);
    while ($urandom_range(99) < gap_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk);
    end
    sample_if.valid <= 1'b1;
    sample_if.action <= act;
    sample_if.channel <= ch;
    sample_if.raw_angle <= raw;
    @(posedge clk);
    while (!sample_if.ready) @(posedge clk);
    pending_moves.push_back(advance_scanner(act, ch, raw));
    walk_angle[ch] = raw;
  endtask

  task automatic settle();
    sample_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves psel high so back-to-back writes need one assignment per edge
  task automatic write_reg(int unsigned idx, logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_DEADBAND: deadband = value[ANGLE_W-1:0];
      REG_HALF:     half_width = value[ANGLE_W-1:0];
      REG_GAIN:     gain = value[GAIN_W-1:0];
      REG_FLOOR:    pwm_floor = value[PWM_W-1:0];
      REG_CEILING:  pwm_ceiling = value[PWM_W-1:0];
      default:      ;
    endcase
  endtask

  task automatic apply_settings(int unsigned db, int unsigned half, int unsigned g,
                                int unsigned fl, int unsigned ce);
    settle();
    write_reg(REG_DEADBAND, db);
    write_reg(REG_HALF, half);
    write_reg(REG_GAIN, g);
    write_reg(REG_FLOOR, fl);
    write_reg(REG_CEILING, ce);
    write_reg(SPARE_REG, $urandom);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // mostly follows the scan direction so the loop reaches and reverses at both ends
  task automatic feed_scan(int count);
    bit                 ch;
    action_t            act;
    logic [ANGLE_W-1:0] raw;
    int                 stride;
    bit                 toward;
    repeat (count) begin
      ch = 1'($urandom_range(1));
      raw = walk_angle[ch];
      if ($urandom_range(99) < 8) begin
        raw = ANGLE_W'($urandom);
      end else begin
        case ($urandom_range(3))
          0:       stride = $urandom_range(300);
          1:       stride = $urandom_range(4000);
          2:       stride = $urandom_range(30000);
          default: stride = $urandom_range(int'(HALF_REV) - 2, int'(HALF_REV) + 2);
        endcase
        toward = scanners[ch].up ^ ($urandom_range(99) < 15);
        raw = toward ? ANGLE_W'(raw + stride) : ANGLE_W'(raw - stride);
      end
      act = ($urandom_range(99) < 6) ? ACT_HOME : ACT_TICK;
      send_sample(act, ch, raw);
    end
  endtask

  task automatic test_unwrap_and_angle();
    send_sample(ACT_TICK, 1'b0, '0);
    send_sample(ACT_TICK, 1'b0, '1);
    send_sample(ACT_HOME, 1'b1, HALF_REV);
    send_sample(ACT_TICK, 1'b1, '0);
    send_sample(ACT_TICK, 1'b1, '1);
    send_sample(ACT_HOME, 1'b0, '0);
    send_sample(ACT_TICK, 1'b0, HALF_REV + 1'b1);
    send_sample(ACT_HOME, 1'b0, '0);
    send_sample(ACT_TICK, 1'b0, HALF_REV);
    send_sample(ACT_TICK, 1'b0, '0);
    send_sample(ACT_TICK, 1'b1, HALF_REV - 1'b1);
    settle();
  endtask

  task automatic test_drive_limits();
    // floor above ceiling, zero gain
    apply_settings(0, int'(HALF_REV), 0, 65535, 0);
    feed_scan(70);
    apply_settings(0, 0, 24'hFFFFFF, 0, 65535);
    feed_scan(70);
    apply_settings(262143, int'(HALF_REV), 24'hFFFFFF, 1, 1);
    feed_scan(70);
    settle();
  endtask

  task automatic test_random_scan();
    int gaps[4];
    int stalls[4];
    gaps = '{0, 56, 0, 27};
    stalls = '{0, 0, 56, 27};
    for (int i = 0; i < 4; i++) begin
      apply_settings(($urandom_range(3) == 0) ? $urandom_range(262143) : $urandom_range(1500),
                     $urandom_range(int'(HALF_REV)), $urandom_range(24'hFFFFFF),
                     $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(200),
                     $urandom_range(65535));
      gap_pct = gaps[i];
      stall_pct = stalls[i];
      feed_scan(260);
    end
    settle();
  endtask

  task automatic test_backpressure();
    apply_settings(256, 20000, 65536, 50, 4000);
    gap_pct = 0;
    stall_pct = 0;
    -> start_hold;
    feed_scan(100);
    settle();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_if.valid = 1'b0;
    sample_if.action = ACT_TICK;
    sample_if.channel = 1'b0;
    sample_if.raw_angle = '0;
    gap_pct = 0;
    stall_pct = 0;
    reset_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unwrap_and_angle();
    test_drive_limits();
    test_random_scan();
    test_backpressure();

    if (mismatches == 0 && pending_moves.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
